FILE: design/amm_pkg.sv
package amm_pkg;

    // accumulator and field widths
    localparam int ACC_WIDTH   = 20;
    localparam int DELTA_WIDTH = 16;
    localparam int WORD_WIDTH  = 16;
    localparam int AXIS_WIDTH  = 7;
    localparam int SUM_WIDTH   = ((ACC_WIDTH > DELTA_WIDTH) ? ACC_WIDTH : DELTA_WIDTH) + 1;

    // axis compression limits
    localparam int AXIS_LIMIT = 127;
    localparam int PASS_LIMIT = 3;
    localparam int HALF_LIMIT = 63;

    typedef enum logic
    {
        OP_EVENT = 1'b0,
        OP_POLL  = 1'b1
    } amm_op_t;

    typedef logic signed [ACC_WIDTH-1:0]   amm_acc_t;
    typedef logic signed [DELTA_WIDTH-1:0] amm_delta_t;

    typedef struct packed
    {
        amm_op_t    operation;
        amm_delta_t delta_x;
        amm_delta_t delta_y;
        logic       left_pressed;
        logic       right_pressed;
    } amm_item_t;

    // saturating add of one signed delta into an accumulator
    function automatic amm_acc_t sat_add(amm_acc_t acc, amm_delta_t d);
        logic signed [SUM_WIDTH-1:0] s;
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        amm_acc_t                    r;
        s  = SUM_WIDTH'(acc) + SUM_WIDTH'(d);
        hi = {{(SUM_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
        lo = ~hi;
        if (s > hi)
        begin
            r = hi[ACC_WIDTH-1:0];
        end
        else if (s < lo)
        begin
            r = lo[ACC_WIDTH-1:0];
        end
        else
        begin
            r = s[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    // clamp to +-127, halve anything beyond +-3, clamp to +-63
    function automatic logic [AXIS_WIDTH-1:0] axis_code(amm_acc_t v);
        logic signed [7:0] c;
        logic signed [7:0] h;
        if (v > amm_acc_t'(AXIS_LIMIT))
        begin
            c = 8'(AXIS_LIMIT);
        end
        else if (v < amm_acc_t'(-AXIS_LIMIT))
        begin
            c = 8'(-AXIS_LIMIT);
        end
        else
        begin
            c = v[7:0];
        end
        h = c >>> 1;
        if (h >= 8'sd63)
        begin
            h = 8'(HALF_LIMIT);
        end
        if (h <= -8'sd63)
        begin
            h = 8'(-HALF_LIMIT);
        end
        if (c > 8'(PASS_LIMIT) || c < 8'(-PASS_LIMIT))
        begin
            c = h;
        end
        return c[AXIS_WIDTH-1:0];
    endfunction

endpackage

FILE: design/amm_event_if.sv
interface amm_event_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic signed [15:0]              delta_x;
    logic signed [15:0]              delta_y;
    logic                            left_pressed;
    logic                            right_pressed;

    modport source (output valid, output operation, output delta_x, output delta_y,
                    output left_pressed, output right_pressed, input ready);
    modport sink (input valid, input operation, input delta_x, input delta_y,
                  input left_pressed, input right_pressed, output ready);
endinterface

FILE: design/amm_word_if.sv
interface amm_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] register_word;

    modport source (output valid, output register_word, input ready);
    modport sink (input valid, input register_word, output ready);
endinterface

FILE: design/amm_cfg_if.sv
interface amm_cfg_if;
    logic valid;
    logic ready;
    logic mouse_enable;

    modport source (output valid, output mouse_enable, input ready);
    modport sink (input valid, input mouse_enable, output ready);
endinterface

FILE: design/adb_mouse_motion_report.sv
// ADB mouse register-0 report block. Motion events on the motion channel are merged into
// saturating 20-bit x/y sums and sticky left/right button flags; a poll request with
// something pending returns one 16-bit register-0 word on the report channel (active-low
// buttons in bits 15 and 7, compressed 7-bit axes) and clears the state, while a poll with
// nothing pending returns nothing. Each request is held in the input register and is
// merged or packed at the edge at which it leaves it, so one request is taken every cycle;
// a report word is loaded into the report register as its poll leaves the input register
// and is offered on the report channel from there; the only stall is a reporting poll
// meeting a full report register that the sink is not draining. Writing mouse_enable to 0
// clears the state and makes the block swallow all requests until it is set again.
module adb_mouse_motion_report
(
    input  logic       clk,
    input  logic       rst_n,
    amm_cfg_if.sink    cfg,
    amm_event_if.sink  motion,
    amm_word_if.source report
);
    import amm_pkg::*;

    amm_item_t             item;
    logic                  item_valid;
    logic                  take;
    logic                  report_valid;
    logic [WORD_WIDTH-1:0] report_word;
    logic                  out_space;

    // a request leaves the input register unless its word has nowhere to go
    assign take = item_valid && (!report_valid || out_space);

    amm_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .motion     (motion),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    amm_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .item_valid   (item_valid),
        .take         (take),
        .report_valid (report_valid),
        .report_word  (report_word)
    );

    amm_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && report_valid),
        .word   (report_word),
        .space  (out_space),
        .report (report)
    );
endmodule

FILE: design/amm_in_stage.sv
module amm_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    amm_event_if.sink          motion,
    input  logic               take,
    output amm_pkg::amm_item_t item,
    output logic               item_valid
);
    import amm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    amm_item_t item_reg;
    logic      accept;

    // stage is free when empty or being drained this cycle
    assign motion.ready = !valid_reg || take;
    assign accept       = motion.valid && motion.ready;
    assign valid_next   = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // capture request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation     <= amm_op_t'(motion.operation);
            item_reg.delta_x       <= motion.delta_x;
            item_reg.delta_y       <= motion.delta_y;
            item_reg.left_pressed  <= motion.left_pressed;
            item_reg.right_pressed <= motion.right_pressed;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;
endmodule

FILE: design/amm_accum.sv
module amm_accum
(
    input  logic                              clk,
    input  logic                              rst_n,
    amm_cfg_if.sink                           cfg,
    input  amm_pkg::amm_item_t                item,
    input  logic                              item_valid,
    input  logic                              take,
    output logic                              report_valid,
    output logic [amm_pkg::WORD_WIDTH-1:0]    report_word
);
    import amm_pkg::*;

    logic     enable_reg;
    logic     enable_next;
    amm_acc_t sum_x_reg;
    amm_acc_t sum_x_next;
    amm_acc_t sum_y_reg;
    amm_acc_t sum_y_next;
    logic     left_seen_reg;
    logic     left_seen_next;
    logic     right_seen_reg;
    logic     right_seen_next;
    logic     pending_reg;
    logic     pending_next;

    // configuration register
    assign cfg.ready   = 1'b1;
    assign enable_next = (cfg.valid && cfg.ready) ? cfg.mouse_enable : enable_reg;

    // merge events, clear on a reporting poll or while disabled
    always_comb
    begin
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        left_seen_next  = left_seen_reg;
        right_seen_next = right_seen_reg;
        pending_next    = pending_reg;
        if (!enable_reg || (take && item.operation == OP_POLL && pending_reg))
        begin
            sum_x_next      = '0;
            sum_y_next      = '0;
            left_seen_next  = 1'b0;
            right_seen_next = 1'b0;
            pending_next    = 1'b0;
        end
        else if (take && item.operation == OP_EVENT)
        begin
            sum_x_next      = sat_add(sum_x_reg, item.delta_x);
            sum_y_next      = sat_add(sum_y_reg, item.delta_y);
            left_seen_next  = left_seen_reg || item.left_pressed;
            right_seen_next = right_seen_reg || item.right_pressed;
            pending_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            left_seen_reg  <= 1'b0;
            right_seen_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            enable_reg     <= enable_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            left_seen_reg  <= left_seen_next;
            right_seen_reg <= right_seen_next;
            pending_reg    <= pending_next;
        end
    end

    // register-0 word for a poll with something pending
    assign report_valid = item_valid && enable_reg && item.operation == OP_POLL && pending_reg;
    assign report_word  = {~left_seen_reg, axis_code(sum_y_reg),
                           ~right_seen_reg, axis_code(sum_x_reg)};
endmodule

FILE: design/amm_out_stage.sv
module amm_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [amm_pkg::WORD_WIDTH-1:0] word,
    output logic                           space,
    amm_word_if.source                     report
);
    import amm_pkg::*;

    logic                  full_reg;
    logic                  full_next;
    logic [WORD_WIDTH-1:0] word_reg;

    // room when empty or the held word leaves this cycle
    assign space     = !full_reg || report.ready;
    assign full_next = load || (full_reg && !report.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign report.valid         = full_reg;
    assign report.register_word = word_reg;
endmodule
